// ===== src/policy_priority_request_queue_macros.svh =====
// assertion macros for the policy priority request queue
`ifndef POLICY_PRIORITY_REQUEST_QUEUE_MACROS_SVH
`define POLICY_PRIORITY_REQUEST_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppq assertion failed");
// next-cycle implication
`define PPQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppq assertion failed");
`else
`define PPQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define PPQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/ppq_pkg.sv =====
// types and constants shared by the policy priority request queue
package ppq_pkg;

   localparam int PRIO_W = 32;
   localparam int TAG_W  = 16;
   localparam int AGE_W  = 16;
   localparam int ARR_W  = 31;
   localparam int TIME_W = 32;
   localparam int CAP_W  = 5;
   localparam int POL_W  = 2;
   localparam int IDX_W  = 2;

   localparam logic OP_INSERT   = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   localparam logic [IDX_W-1:0] REG_QUEUE_POLICY    = 2'd0;
   localparam logic [IDX_W-1:0] REG_CAPACITY_IN_USE = 2'd1;
   localparam logic [IDX_W-1:0] REG_START_TIME_MS   = 2'd2;

   localparam logic [POL_W-1:0] POLICY_FIFO        = 2'd0;
   localparam logic [POL_W-1:0] POLICY_FAVOR_PICS  = 2'd1;
   localparam logic [POL_W-1:0] POLICY_FAVOR_HTML  = 2'd2;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
   localparam logic [AGE_W-1:0] AGE_MAX        = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_INSERTED   = 2'd0,
      ST_FULL       = 2'd1,
      ST_EMPTY      = 2'd2,
      ST_DISPATCHED = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]         tag;
      logic [AGE_W-1:0]         age;
   } slot_type;

   typedef struct packed {
      logic                     ins;
      logic                     pop;
      logic signed [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]         tag;
   } cmd_type;

   // int_max - a is the bitwise complement of a over 31 bits
   function automatic logic signed [PRIO_W-1:0] calc_prio(
      input logic [POL_W-1:0] policy,
      input logic [ARR_W-1:0] arrival,
      input logic             html
   );
      logic signed [PRIO_W-1:0] high;
      logic signed [PRIO_W-1:0] low;
      logic signed [PRIO_W-1:0] res;
      high = {1'b0, ~arrival};
      low  = -$signed({1'b0, arrival});
      case (policy)
         POLICY_FIFO:       res = high;
         POLICY_FAVOR_PICS: res = html ? low : high;
         POLICY_FAVOR_HTML: res = html ? high : low;
         default:           res = '0;
      endcase
      return res;
   endfunction

endpackage

// ===== src/ppq_req_if.sv =====
// request channel of the priority queue
interface ppq_req_if;
   logic                            valid;
   logic                            ready;
   logic                            operation;
   logic [ppq_pkg::ARR_W-1:0]       arrival_number;
   logic                            is_html;
   logic [ppq_pkg::TAG_W-1:0]       entry_tag;
   logic [ppq_pkg::TIME_W-1:0]      now_ms;

   modport source (output valid, operation, arrival_number, is_html, entry_tag, now_ms,
                   input ready);
   modport sink (input valid, operation, arrival_number, is_html, entry_tag, now_ms,
                 output ready);
endinterface

// ===== src/ppq_rsp_if.sv =====
// response channel of the priority queue
interface ppq_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 status;
   logic [ppq_pkg::TAG_W-1:0]  out_tag;
   logic [ppq_pkg::AGE_W-1:0]  out_age;
   logic [ppq_pkg::TIME_W-1:0] dispatch_sequence;
   logic [ppq_pkg::TIME_W-1:0] dispatch_delay_ms;

   modport source (output valid, status, out_tag, out_age, dispatch_sequence,
                   dispatch_delay_ms, input ready);
   modport sink (input valid, status, out_tag, out_age, dispatch_sequence,
                 dispatch_delay_ms, output ready);
endinterface

// ===== src/ppq_csr_if.sv =====
// register write channel of the priority queue
interface ppq_csr_if;
   logic                       valid;
   logic                       ready;
   logic [ppq_pkg::IDX_W-1:0]  index;
   logic [ppq_pkg::TIME_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ppq_cell.sv =====
// one slot of the sorted queue row
module ppq_cell (
   input  logic              clock,
   input  ppq_pkg::cmd_type  cmd,
   input  logic              occ,
   input  logic              prev_le,
   input  ppq_pkg::slot_type prev_slot,
   input  ppq_pkg::slot_type next_slot,
   output ppq_pkg::slot_type slot,
   output logic              le
);

   ppq_pkg::slot_type slot_ff;
   ppq_pkg::slot_type slot_in;

   // occupied and not above the new priority: moves down and ages
   assign le   = occ && ($signed(slot_ff.prio) <= $signed(cmd.prio));
   assign slot = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (cmd.pop) begin
         slot_in = next_slot;
      end else if (cmd.ins) begin
         if (prev_le) begin
            slot_in = prev_slot;
            if (prev_slot.age != ppq_pkg::AGE_MAX) begin
               slot_in.age = prev_slot.age + 1'b1;
            end
         end else if (le || !occ) begin
            slot_in.prio = cmd.prio;
            slot_in.tag  = cmd.tag;
            slot_in.age  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// ===== src/policy_priority_request_queue.sv =====
// top level of the policy priority request queue
//
//   channel  dir  handshake      beat
//   req      in   valid/ready    operation, arrival, kind, tag, time
//   rsp      out  valid/ready    status, tag, age, sequence, delay
//   csr      in   valid/ready    register index and write data
//
// one beat per cycle: a request is accepted and its response is in the
// output register at the next edge; the whole insert or pop is one pass
// across the row of cells, set by the 32-bit priority compare in each cell
// reset is synchronous; it empties the queue and restores register defaults
// req is held off only while a response waits and rsp is stalled
`include "policy_priority_request_queue_macros.svh"

module policy_priority_request_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic clock,
   input logic reset,
   ppq_req_if.sink   req_if,
   ppq_rsp_if.source rsp_if,
   ppq_csr_if.sink   csr_if
);

   // occupancy count needs to hold the full depth
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int CMPW = (CW > ppq_pkg::CAP_W) ? CW : ppq_pkg::CAP_W;

   // configuration registers
   logic [ppq_pkg::POL_W-1:0]  policy_ff;
   logic [ppq_pkg::CAP_W-1:0]  capacity_ff;
   logic [ppq_pkg::TIME_W-1:0] start_ff;

   // queue control
   logic [CW-1:0]              count_ff;
   logic [CW-1:0]              count_in;
   logic [ppq_pkg::TIME_W-1:0] disp_cnt_ff;
   logic [ppq_pkg::TIME_W-1:0] disp_cnt_in;

   // response register
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   ppq_pkg::status_type        status_ff;
   ppq_pkg::status_type        status_in;
   logic [ppq_pkg::TAG_W-1:0]  tag_ff;
   logic [ppq_pkg::TAG_W-1:0]  tag_in;
   logic [ppq_pkg::AGE_W-1:0]  age_ff;
   logic [ppq_pkg::AGE_W-1:0]  age_in;
   logic [ppq_pkg::TIME_W-1:0] seq_ff;
   logic [ppq_pkg::TIME_W-1:0] seq_in;
   logic [ppq_pkg::TIME_W-1:0] delay_ff;
   logic [ppq_pkg::TIME_W-1:0] delay_in;

   logic              accept;
   logic              is_full;
   logic              is_empty;
   ppq_pkg::cmd_type  cmd;

   // chain wiring between cells
   ppq_pkg::slot_type cell_slot [QUEUE_DEPTH];
   logic              cell_le   [QUEUE_DEPTH];

   // output register frees as soon as its beat is taken
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   // full when at the programmed capacity or at the physical depth
   assign is_full  = (CMPW'(count_ff) >= CMPW'(capacity_ff)) ||
                     (count_ff == CW'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   // command broadcast to every cell
   always_comb begin
      cmd.ins  = accept && (req_if.operation == ppq_pkg::OP_INSERT) && !is_full;
      cmd.pop  = accept && (req_if.operation == ppq_pkg::OP_DISPATCH) && !is_empty;
      cmd.prio = ppq_pkg::calc_prio(policy_ff, req_if.arrival_number, req_if.is_html);
      cmd.tag  = req_if.entry_tag;
   end

   // cell 0 holds the highest priority, ties with the newest entry first
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic              prev_le;
      ppq_pkg::slot_type prev_slot;
      ppq_pkg::slot_type next_slot;

      if (i == 0) begin : g_first
         assign prev_le   = 1'b0;
         assign prev_slot = cell_slot[i];
      end else begin : g_mid
         assign prev_le   = cell_le[i-1];
         assign prev_slot = cell_slot[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_slot = cell_slot[i];
      end else begin : g_inner
         assign next_slot = cell_slot[i+1];
      end

      ppq_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occ       (CW'(i) < count_ff),
         .prev_le   (prev_le),
         .prev_slot (prev_slot),
         .next_slot (next_slot),
         .slot      (cell_slot[i]),
         .le        (cell_le[i])
      );
   end

   // next count, counter and response
   always_comb begin
      count_in     = count_ff;
      disp_cnt_in  = disp_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      tag_in       = tag_ff;
      age_in       = age_ff;
      seq_in       = seq_ff;
      delay_in     = delay_ff;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         tag_in       = '0;
         age_in       = '0;
         seq_in       = '0;
         delay_in     = '0;
         if (req_if.operation == ppq_pkg::OP_INSERT) begin
            if (is_full) begin
               status_in = ppq_pkg::ST_FULL;
            end else begin
               status_in = ppq_pkg::ST_INSERTED;
               count_in  = count_ff + 1'b1;
            end
         end else if (is_empty) begin
            status_in = ppq_pkg::ST_EMPTY;
         end else begin
            // pop the head cell
            status_in   = ppq_pkg::ST_DISPATCHED;
            count_in    = count_ff - 1'b1;
            tag_in      = cell_slot[0].tag;
            age_in      = cell_slot[0].age;
            seq_in      = disp_cnt_ff;
            delay_in    = req_if.now_ms - start_ff;
            disp_cnt_in = disp_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= ppq_pkg::POLICY_FIFO;
         capacity_ff  <= ppq_pkg::CAPACITY_RESET;
         start_ff     <= '0;
         count_ff     <= '0;
         disp_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         disp_cnt_ff  <= disp_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         // register writes; unknown indexes are dropped
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               ppq_pkg::REG_QUEUE_POLICY:    policy_ff   <= csr_if.data[ppq_pkg::POL_W-1:0];
               ppq_pkg::REG_CAPACITY_IN_USE: capacity_ff <= csr_if.data[ppq_pkg::CAP_W-1:0];
               ppq_pkg::REG_START_TIME_MS:   start_ff    <= csr_if.data;
               default: ;
            endcase
         end
      end
   end

   // response payload needs no reset
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      tag_ff    <= tag_in;
      age_ff    <= age_in;
      seq_ff    <= seq_in;
      delay_ff  <= delay_in;
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.status            = status_ff;
   assign rsp_if.out_tag           = tag_ff;
   assign rsp_if.out_age           = age_ff;
   assign rsp_if.dispatch_sequence = seq_ff;
   assign rsp_if.dispatch_delay_ms = delay_ff;

   // occupancy never passes the row length
   `PPQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(QUEUE_DEPTH))
   // an accepted insert that fits grows the queue by one
   `PPQ_ASSERT_NXT(a_insert_grows, clock, reset, cmd.ins,
                   (count_ff == $past(count_ff) + 1'b1) && (status_ff == ppq_pkg::ST_INSERTED))
   // a dispatch from an empty queue reports empty and leaves the counter alone
   `PPQ_ASSERT_NXT(a_empty_pop, clock, reset,
                   accept && (req_if.operation == ppq_pkg::OP_DISPATCH) && is_empty,
                   (status_ff == ppq_pkg::ST_EMPTY) && (disp_cnt_ff == $past(disp_cnt_ff)))
   // each real dispatch advances the sequence counter by one
   `PPQ_ASSERT_NXT(a_pop_counts, clock, reset, cmd.pop,
                   (disp_cnt_ff == $past(disp_cnt_ff) + 1'b1) &&
                   (seq_ff == $past(disp_cnt_ff)))

endmodule
